[design/lfe_pkg.sv]
// Shared types, constants and the B3/S23 rule function for the life row engine.
`default_nettype none

package lfe_pkg;

    localparam int ROW_W           = 64;
    localparam int COLS_W          = 7;
    localparam int MAX_COLUMNS_DEF = 64;
    localparam logic [COLS_W-1:0] COLS_RESET = 7'd64;
    localparam int FIFO_DEPTH      = 4;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic [ROW_W-1:0] row_cells;
        logic             first_row;
        logic             last_row;
    } t_lfe_in;

    typedef struct packed {
        logic [ROW_W-1:0] next_row_cells;
        logic             last_of_grid;
    } t_lfe_out;

    // Per-cycle control broadcast along the cell chain.
    typedef struct packed {
        logic take;   // input request accepted this cycle
        logic open;   // no row above: first row or nothing pending
        logic last;   // accepted row is the bottom row
    } t_lfe_ctl;

    // nbr holds the eight neighbors; center is the cell itself.
    function automatic logic lfe_rule(input logic [7:0] nbr, input logic center);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int k = 0; k < 8; k++) begin
            cnt = cnt + {3'd0, nbr[k]};
        end
        return (cnt == BIRTH_COUNT) || ((cnt == SURVIVE_COUNT) && center);
    endfunction

endpackage

`default_nettype wire

[design/lfe_cell.sv]
// One column cell: holds the above and pending bits and evaluates both candidate results.
`default_nettype none

module lfe_cell (
    input  wire logic              i_clk,
    input  wire lfe_pkg::t_lfe_ctl i_ctl,
    input  wire logic              i_en,
    input  wire logic              i_in_bit,
    input  wire logic              i_in_l,
    input  wire logic              i_in_r,
    input  wire logic              i_above_l,
    input  wire logic              i_above_r,
    input  wire logic              i_pend_l,
    input  wire logic              i_pend_r,
    output logic                   o_in_bit,
    output logic                   o_above,
    output logic                   o_pend,
    output logic                   o_res_mid,
    output logic                   o_res_last
);

    logic r_above;
    logic r_pend;
    logic n_above;
    logic n_pend;
    logic w_new_above;

    assign o_in_bit = i_in_bit & i_en;
    assign o_above  = r_above & i_en;
    assign o_pend   = r_pend & i_en;

    // Row above the incoming row: the pending bit, dead when the row is first or nothing is pending.
    assign w_new_above = o_pend & ~i_ctl.open;

    // Next state of the pending row, completed by the incoming row.
    assign o_res_mid = i_en & lfe_pkg::lfe_rule(
        {i_above_l, o_above, i_above_r, i_pend_l, i_pend_r, i_in_l, o_in_bit, i_in_r},
        o_pend);

    // Next state of the incoming row with a dead row below.
    assign o_res_last = i_en & lfe_pkg::lfe_rule(
        {i_pend_l & ~i_ctl.open, w_new_above, i_pend_r & ~i_ctl.open,
         i_in_l, i_in_r, 1'b0, 1'b0, 1'b0},
        o_in_bit);

    always_comb begin
        n_above = r_above;
        n_pend  = r_pend;
        if (i_ctl.take) begin
            if (i_ctl.last) begin
                n_above = 1'b0;
                n_pend  = 1'b0;
            end else begin
                n_above = w_new_above;
                n_pend  = o_in_bit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_above <= n_above;
        r_pend  <= n_pend;
    end

endmodule

`default_nettype wire

[design/lfe_out_fifo.sv]
// Small result queue taking up to two results per cycle and releasing one per cycle unless stalled.
`default_nettype none

module lfe_out_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push0,
    input  wire logic              i_push1,
    input  wire lfe_pkg::t_lfe_out i_data0,
    input  wire lfe_pkg::t_lfe_out i_data1,
    input  wire logic              i_stall,
    output logic                   o_valid,
    output lfe_pkg::t_lfe_out      o_data,
    output logic                   o_almost_full
);

    localparam int PTR_W = $clog2(lfe_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(lfe_pkg::FIFO_DEPTH + 1);

    lfe_pkg::t_lfe_out r_mem [lfe_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_pop;

    assign o_valid       = (r_count != '0);
    assign o_data        = r_mem[r_rd_ptr];
    assign w_pop         = o_valid & ~i_stall;
    // Room for two more results is needed before a row is taken.
    assign o_almost_full = (r_count > CNT_W'(lfe_pkg::FIFO_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'({1'b0, i_push0}) + PTR_W'({1'b0, i_push1});
        n_rd_ptr = r_rd_ptr + PTR_W'({1'b0, w_pop});
        n_count  = r_count + CNT_W'({1'b0, i_push0}) + CNT_W'({1'b0, i_push1})
                   - CNT_W'({1'b0, w_pop});
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

[design/life_generation_row_engine_unit.sv]
// Top level of the Game of Life (B3/S23) row engine: cell chain, control and result queue.
`default_nettype none

// Takes one grid row per request, top to bottom, and returns the next generation of
// the row before it; a row marked last also returns its own next state, flagged with
// last_of_grid. A chain of MAX_COLUMNS column cells holds the previous two rows and
// evaluates every column side by side combinationally, so a row is taken every cycle
// while the input is not stalled. Results are registered in a four-entry queue when
// their row is taken. A bottom row yields up to two results, but the first row of a
// grid yields none, so the one-result-per-cycle output keeps up while not stalled and
// rows flow back to back; the input stalls only while the queue holds three or more
// results, which happens only when the output is stalled. A row marked first drops
// any unfinished grid. Columns at or above columns_in_use (reset 64) read and write
// as dead; the register may be written only while no request is in flight.
module life_generation_row_engine_unit #(
    parameter int MAX_COLUMNS = lfe_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire lfe_pkg::t_lfe_in           i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output lfe_pkg::t_lfe_out               o_out_data,
    input  wire logic                       i_cfg_we,
    input  wire logic [lfe_pkg::COLS_W-1:0] i_cfg_wdata
);

    logic [lfe_pkg::COLS_W-1:0] r_cols;
    logic                       r_pend_valid;
    logic                       n_pend_valid;
    logic [lfe_pkg::COLS_W-1:0] w_cols_eff;
    logic                       w_accept;
    logic                       w_almost_full;
    logic                       w_push0;
    logic                       w_push1;
    lfe_pkg::t_lfe_ctl          w_ctl;
    lfe_pkg::t_lfe_out          w_data0;
    lfe_pkg::t_lfe_out          w_data1;

    logic [MAX_COLUMNS-1:0]     w_en;
    logic [MAX_COLUMNS+1:0]     w_in_m;
    logic [MAX_COLUMNS+1:0]     w_above;
    logic [MAX_COLUMNS+1:0]     w_pend;
    logic [lfe_pkg::ROW_W-1:0]  w_res_mid;
    logic [lfe_pkg::ROW_W-1:0]  w_res_last;

    assign w_cols_eff = (r_cols > lfe_pkg::COLS_W'(MAX_COLUMNS))
                        ? lfe_pkg::COLS_W'(MAX_COLUMNS) : r_cols;

    assign o_in_stall = w_almost_full;
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_ctl.take = w_accept;
    assign w_ctl.open = i_in_data.first_row | ~r_pend_valid;
    assign w_ctl.last = i_in_data.last_row;

    // Dead columns beyond both ends of the chain.
    assign w_in_m[0]               = 1'b0;
    assign w_in_m[MAX_COLUMNS+1]   = 1'b0;
    assign w_above[0]              = 1'b0;
    assign w_above[MAX_COLUMNS+1]  = 1'b0;
    assign w_pend[0]               = 1'b0;
    assign w_pend[MAX_COLUMNS+1]   = 1'b0;

    for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_cell
        assign w_en[c] = (lfe_pkg::COLS_W'(c) < w_cols_eff);

        lfe_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_en      (w_en[c]),
            .i_in_bit  (i_in_data.row_cells[c]),
            .i_in_l    (w_in_m[c]),
            .i_in_r    (w_in_m[c+2]),
            .i_above_l (w_above[c]),
            .i_above_r (w_above[c+2]),
            .i_pend_l  (w_pend[c]),
            .i_pend_r  (w_pend[c+2]),
            .o_in_bit  (w_in_m[c+1]),
            .o_above   (w_above[c+1]),
            .o_pend    (w_pend[c+1]),
            .o_res_mid (w_res_mid[c]),
            .o_res_last(w_res_last[c])
        );
    end

    if (MAX_COLUMNS < lfe_pkg::ROW_W) begin : g_dead_hi
        assign w_res_mid[lfe_pkg::ROW_W-1:MAX_COLUMNS]  = '0;
        assign w_res_last[lfe_pkg::ROW_W-1:MAX_COLUMNS] = '0;
    end

    // Pending row's result goes first; the bottom row's own result follows.
    assign w_push0 = w_accept & (~w_ctl.open | w_ctl.last);
    assign w_push1 = w_accept & ~w_ctl.open & w_ctl.last;

    assign w_data0.next_row_cells = w_ctl.open ? w_res_last : w_res_mid;
    assign w_data0.last_of_grid   = w_ctl.open;
    assign w_data1.next_row_cells = w_res_last;
    assign w_data1.last_of_grid   = 1'b1;

    lfe_out_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push0      (w_push0),
        .i_push1      (w_push1),
        .i_data0      (w_data0),
        .i_data1      (w_data1),
        .i_stall      (i_out_stall),
        .o_valid      (o_out_valid),
        .o_data       (o_out_data),
        .o_almost_full(w_almost_full)
    );

    always_comb begin
        n_pend_valid = r_pend_valid;
        if (w_accept) begin
            n_pend_valid = ~i_in_data.last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols       <= lfe_pkg::COLS_RESET;
            r_pend_valid <= 1'b0;
        end else begin
            r_pend_valid <= n_pend_valid;
            if (i_cfg_we) begin
                r_cols <= i_cfg_wdata;
            end
        end
    end

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the Game of Life row engine (B3/S23, dead borders).
module testbench;
    import lfe_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_CAP    = 40;

    logic              i_clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    t_lfe_in           in_data = '0;
    logic              out_stall = 1'b0;
    logic              cfg_we = 1'b0;
    logic [COLS_W-1:0] cfg_wdata = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_lfe_out          o_out_data;

    // shadow state of the engine
    logic [COLS_W-1:0] cols_in_use = COLS_RESET;
    logic [ROW_W-1:0]  row_above = '0;
    logic [ROW_W-1:0]  row_pending = '0;
    logic              pend_valid = 1'b0;
    t_lfe_out          next_rows_due[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_cycles_req = 0;
    int mismatch_count = 0;
    int rows_taken = 0;
    int results_checked = 0;
    int width_writes = 0;
    int cycle_count = 0;

    life_generation_row_engine_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever begin
            #HALF_PERIOD i_clk = ~i_clk;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // Receiver: random stall, or a long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles_req > 0) begin
                out_stall <= 1'b1;
                repeat (hold_cycles_req) @(posedge i_clk);
                hold_cycles_req = 0;
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    function automatic logic [ROW_W-1:0] col_mask(input logic [COLS_W-1:0] cols);
        if (cols >= ROW_W)
            return '1;
        return (64'd1 << cols) - 64'd1;
    endfunction

    function automatic logic [ROW_W-1:0] life_step(input logic [ROW_W-1:0] up,
                                                    input logic [ROW_W-1:0] mid,
                                                    input logic [ROW_W-1:0] down,
                                                    input logic [ROW_W-1:0] mask);
        logic [ROW_W-1:0] nxt;
        int n;
        nxt = '0;
        up = up & mask;
        mid = mid & mask;
        down = down & mask;
        for (int c = 0; c < ROW_W; c++) begin
            n = int'(up[c]) + int'(down[c]);
            if (c > 0)
                n += int'(up[c-1]) + int'(mid[c-1]) + int'(down[c-1]);
            if (c < ROW_W - 1)
                n += int'(up[c+1]) + int'(mid[c+1]) + int'(down[c+1]);
            nxt[c] = (n == int'(BIRTH_COUNT)) || ((n == int'(SURVIVE_COUNT)) && mid[c]);
        end
        return nxt & mask;
    endfunction

    task automatic life_predict_row(input t_lfe_in r);
        logic [ROW_W-1:0] mask;
        logic [ROW_W-1:0] cells;
        logic [ROW_W-1:0] above;
        t_lfe_out res;
        mask = col_mask(cols_in_use);
        cells = r.row_cells & mask;
        if (r.first_row || !pend_valid) begin
            above = '0;
        end else begin
            res.next_row_cells = life_step(row_above, row_pending, cells, mask);
            res.last_of_grid = 1'b0;
            next_rows_due.push_back(res);
            above = row_pending & mask;
        end
        if (r.last_row) begin
            res.next_row_cells = life_step(above, cells, '0, mask);
            res.last_of_grid = 1'b1;
            next_rows_due.push_back(res);
            row_above = '0;
            row_pending = '0;
            pend_valid = 1'b0;
        end else begin
            row_above = above;
            row_pending = cells;
            pend_valid = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [ROW_W-1:0] want,
                                   input logic [ROW_W-1:0] got);
        if (mismatch_count < REPORT_CAP)
            $display("mismatch on %s at cycle %0d: expected %h, got %h",
                     what, cycle_count, want, got);
        mismatch_count++;
    endtask

    // Predict on each accepted request, then check each accepted result.
    always @(posedge i_clk) begin
        t_lfe_out want;
        if (rst_n) begin
            if (in_valid && !o_in_stall) begin
                life_predict_row(in_data);
                rows_taken++;
            end
            if (o_out_valid && !out_stall) begin
                if (next_rows_due.size() == 0) begin
                    report_mismatch("unexpected result", '0, o_out_data.next_row_cells);
                end else begin
                    want = next_rows_due.pop_front();
                    if (o_out_data.next_row_cells !== want.next_row_cells)
                        report_mismatch("next_row_cells", want.next_row_cells,
                                        o_out_data.next_row_cells);
                    if (o_out_data.last_of_grid !== want.last_of_grid)
                        report_mismatch("last_of_grid", ROW_W'(want.last_of_grid),
                                        ROW_W'(o_out_data.last_of_grid));
                    results_checked++;
                end
            end
        end
    end

    task automatic send_row(input logic [ROW_W-1:0] cells, input logic first, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= '{row_cells: cells, first_row: first, last_row: last};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (next_rows_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_columns(input logic [COLS_W-1:0] cols);
        cfg_wdata <= cols;
        cfg_we <= 1'b1;
        @(posedge i_clk);
        cols_in_use = cols;
        cfg_we <= 1'b0;
        width_writes++;
    endtask

    // Extremes first, then random widths.
    function automatic logic [COLS_W-1:0] pick_columns(input int n);
        case (n)
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd127;
            3: return 7'd2;
            4: return 7'd3;
            5: return 7'd65;
            6: return 7'd63;
            7: return 7'd64;
            default: begin
                if ($urandom_range(0, 9) == 0)
                    return 7'($urandom_range(0, 127));
                return 7'($urandom_range(1, 64));
            end
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return a & b;
            1: return a | b;
            2: return a & b & {$urandom, $urandom};
            3: return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: return a;
        endcase
    endfunction

    task automatic do_reset();
        rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_directed_patterns();
        tx_idle_pct = 13;
        rx_idle_pct = 51;
        // single-row grids: full and empty
        send_row('1, 1'b1, 1'b1);
        send_row('0, 1'b1, 1'b1);
        // blinker flips to vertical
        send_row('0, 1'b1, 1'b0);
        send_row(64'h1C0, 1'b0, 1'b0);
        send_row('0, 1'b0, 1'b1);
        // full block: only the corners survive, edges and interior die
        send_row('1, 1'b1, 1'b0);
        send_row('1, 1'b0, 1'b0);
        send_row('1, 1'b0, 1'b1);
        // cells at both outer columns
        send_row(64'hC000_0000_0000_0003, 1'b1, 1'b0);
        send_row(64'h8000_0000_0000_0001, 1'b0, 1'b0);
        send_row(64'hC000_0000_0000_0003, 1'b0, 1'b1);
        // new first row drops the open grid
        send_row(64'h0000_00F0_0F00_0000, 1'b1, 1'b0);
        send_row(64'h0000_0070_0E00_0000, 1'b0, 1'b0);
        send_row(64'h0000_0000_0000_0E00, 1'b1, 1'b0);
        send_row(64'h0000_0000_0000_0700, 1'b0, 1'b1);
        // row with no grid open starts one
        send_row(64'h5555_AAAA_5555_AAAA, 1'b0, 1'b0);
        send_row(64'hAAAA_5555_AAAA_5555, 1'b0, 1'b1);
        // last-only row with nothing pending
        send_row(64'h0F0F_F0F0_0F0F_F0F0, 1'b0, 1'b1);
        // glider
        send_row(64'h2, 1'b1, 1'b0);
        send_row(64'h4, 1'b0, 1'b0);
        send_row(64'h7, 1'b0, 1'b0);
        send_row('0, 1'b0, 1'b1);
        drain_results();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_rows);
        int sent;
        int since_cfg;
        int height;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        since_cfg = 0;
        while (sent < n_rows) begin
            if (since_cfg >= 90) begin
                drain_results();
                set_columns(pick_columns(width_writes));
                since_cfg = 0;
            end
            if ($urandom_range(0, 9) == 0) begin
                // noise row with arbitrary marks
                send_row(rand_row(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
                since_cfg++;
            end else begin
                height = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8);
                for (int k = 0; k < height; k++) begin
                    // now and then abandon the grid before its bottom row
                    if (k > 0 && $urandom_range(0, 59) == 0)
                        break;
                    send_row(rand_row(), k == 0, k == height - 1);
                    sent++;
                    since_cfg++;
                end
            end
        end
        drain_results();
    endtask

    task automatic test_output_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_columns(7'd64);
        hold_cycles_req = 300;
        for (int k = 0; k < 40; k++)
            send_row(rand_row(), k % 10 == 0, k % 10 == 9);
        drain_results();
    endtask

    initial begin
        do_reset();
        test_directed_patterns();
        test_random_traffic(13, 51, 420);
        test_random_traffic(51, 13, 420);
        test_random_traffic(0, 0, 420);
        test_output_backpressure();
        drain_results();
        $display("rows sent %0d, results checked %0d, width writes %0d",
                 rows_taken, results_checked, width_writes);
        $display("covered widths 0..127, broken grids, long output hold-off");
        if (mismatch_count == 0 && next_rows_due.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
